/* src/cdf_pkg.sv */
package cdf_pkg;

	localparam int MAX_TAPS    = 64;
	localparam int TAP_AW      = 6;
	localparam int SAMPLE_BITS = 16;
	localparam int TAP_BITS    = 18;
	localparam int CFG_W       = 7;
	localparam int POS_W       = 16;
	localparam int ISAMP_W     = POS_W + CFG_W;
	localparam int S_W         = ISAMP_W + 1;
	localparam int PROD_W      = TAP_BITS + SAMPLE_BITS;
	localparam int ACC_W       = PROD_W + TAP_AW;
	localparam int RND_SHIFT   = TAP_BITS - 2;
	localparam int RESULT_CAP  = 33;
	localparam int NRES_W      = 6;

	localparam int IN_Q_DEPTH  = 2;
	localparam int RES_Q_DEPTH = 4;

	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 3;

	localparam logic [POS_W-1:0] COUNT_LIMIT = {POS_W{1'b1}};

	localparam logic REQ_TAP    = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic REG_NUM_TAPS   = 1'b0;
	localparam logic REG_DECIM_RATE = 1'b1;

	localparam logic [CFG_W-1:0] NUM_TAPS_RST   = 7'd16;
	localparam logic [CFG_W-1:0] DECIM_RATE_RST = 7'd1;

	typedef struct packed {
		logic                          is_sample;
		logic [TAP_AW-1:0]             tap_index;
		logic signed [TAP_BITS-1:0]    tap_value;
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
		logic                          pulse_end;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_i;
		logic signed [SAMPLE_BITS-1:0] out_q;
		logic [POS_W-1:0]              out_position;
		logic                          last_of_pulse;
		logic                          clipped;
	} result_t;

endpackage

/* src/cdf_front.sv */
module cdf_front (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	output logic                                     full,
	input  logic                                     req_type,
	input  logic [cdf_pkg::TAP_AW-1:0]               tap_index,
	input  logic signed [cdf_pkg::TAP_BITS-1:0]      tap_value,
	input  logic signed [cdf_pkg::SAMPLE_BITS-1:0]   sample_i,
	input  logic signed [cdf_pkg::SAMPLE_BITS-1:0]   sample_q,
	input  logic                                     pulse_end,
	output logic                                     item_valid,
	output cdf_pkg::item_t                           item,
	input  logic                                     item_pop
);

	localparam int PW = $clog2(cdf_pkg::IN_Q_DEPTH);

	cdf_pkg::item_t ent_q [cdf_pkg::IN_Q_DEPTH];
	cdf_pkg::item_t new_item;
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    cnt_q;
	logic           wr_en;
	logic           rd_en;

	// a tap write never ends a pulse
	always_comb begin
		new_item.is_sample = (req_type == cdf_pkg::REQ_SAMPLE);
		new_item.tap_index = tap_index;
		new_item.tap_value = tap_value;
		new_item.sample_i  = sample_i;
		new_item.sample_q  = sample_q;
		new_item.pulse_end = pulse_end && (req_type == cdf_pkg::REQ_SAMPLE);
	end

	assign full       = (cnt_q == (PW+1)'(cdf_pkg::IN_Q_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = ent_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

endmodule

/* src/cdf_res_q.sv */
module cdf_res_q (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    res_push,
	input  cdf_pkg::result_t                        res,
	output logic                                    res_full,
	output logic                                    empty,
	input  logic                                    pop,
	output logic signed [cdf_pkg::SAMPLE_BITS-1:0]  out_i,
	output logic signed [cdf_pkg::SAMPLE_BITS-1:0]  out_q,
	output logic [cdf_pkg::POS_W-1:0]               out_position,
	output logic                                    last_of_pulse,
	output logic                                    clipped
);

	localparam int PW = $clog2(cdf_pkg::RES_Q_DEPTH);

	cdf_pkg::result_t ent_q [cdf_pkg::RES_Q_DEPTH];
	cdf_pkg::result_t head;
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign res_full = (cnt_q == (PW+1)'(cdf_pkg::RES_Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;
	assign head     = ent_q[rd_ptr_q];

	assign out_i         = head.out_i;
	assign out_q         = head.out_q;
	assign out_position  = head.out_position;
	assign last_of_pulse = head.last_of_pulse;
	assign clipped       = head.clipped;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(wr_en) - (PW+1)'(rd_en);
		end
	end

endmodule

/* src/cdf_back.sv */
module cdf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cdf_pkg::CFG_W-1:0]     num_taps,
	input  logic [cdf_pkg::CFG_W-1:0]     decim_rate,
	input  logic                          item_valid,
	input  cdf_pkg::item_t                item,
	output logic                          item_pop,
	input  logic                          res_full,
	output logic                          res_push,
	output cdf_pkg::result_t              res
);

	localparam int SB     = cdf_pkg::SAMPLE_BITS;
	localparam int CW     = cdf_pkg::CFG_W;
	localparam int AW     = cdf_pkg::TAP_AW;
	localparam int IW     = cdf_pkg::ISAMP_W;
	localparam int SW     = cdf_pkg::S_W;
	localparam int ACC_W  = cdf_pkg::ACC_W;
	localparam int RSH    = cdf_pkg::RND_SHIFT;
	localparam int RW     = ACC_W + 1 - RSH;
	localparam int NW     = cdf_pkg::NRES_W;
	localparam int PSW    = cdf_pkg::POS_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_MAC   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_RND   = 3'd5;
	localparam logic [2:0] ST_PUSH  = 3'd6;

	logic [2:0]                     state_q;
	logic [cdf_pkg::POS_W-1:0]      count_q;
	logic [cdf_pkg::POS_W-1:0]      pos_q;
	logic                           pe_q;
	logic [NW-1:0]                  nres_q;
	logic [IW-1:0]                  isamp_q;
	logic signed [SW-1:0]           s_q;
	logic [AW-1:0]                  i_q;

	logic [2*SB-1:0]                dly_mem [cdf_pkg::MAX_TAPS];
	logic signed [cdf_pkg::TAP_BITS-1:0] coef_mem [cdf_pkg::MAX_TAPS];

	logic [2*SB-1:0]                dly_rd_s1;
	logic signed [cdf_pkg::TAP_BITS-1:0] coef_rd_s1;
	logic                           act_s1;
	logic                           win_s1;
	logic signed [cdf_pkg::PROD_W-1:0] prod_re_s2;
	logic signed [cdf_pkg::PROD_W-1:0] prod_im_s2;
	logic                           act_s2;
	logic signed [ACC_W-1:0]        acc_re_q;
	logic signed [ACC_W-1:0]        acc_im_q;

	logic signed [SB-1:0]           r_i_q;
	logic signed [SB-1:0]           r_q_q;
	logic                           r_clip_q;
	logic                           r_last_q;

	logic [CW-1:0]                  n_eff;
	logic [CW-1:0]                  half;
	logic [CW-1:0]                  lag;
	logic [CW-1:0]                  d_eff;
	logic [IW-1:0]                  lim;
	logic                           emit_ok;
	logic                           in_win;
	logic signed [SW-1:0]           cnt_s;
	logic                           dly_we;
	logic                           coef_we;
	logic [SB:0]                    rs_re;
	logic [SB:0]                    rs_im;

	// round half up at the q1.16 point, then saturate; msb of the result is the clip flag
	function automatic logic [SB:0] rnd_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] t;
		logic [RW-1:0]         r;
		logic                  ovf;
		t   = $signed({a[ACC_W-1], a}) + (ACC_W+1)'(1 << (RSH - 1));
		r   = t[ACC_W:RSH];
		ovf = !((&r[RW-1:SB-1]) || !(|r[RW-1:SB-1]));
		if (!ovf) begin
			rnd_sat = {1'b0, r[SB-1:0]};
		end else if (r[RW-1]) begin
			rnd_sat = {1'b1, 1'b1, {(SB-1){1'b0}}};
		end else begin
			rnd_sat = {1'b1, 1'b0, {(SB-1){1'b1}}};
		end
	endfunction

	always_comb begin
		if (num_taps == '0) begin
			n_eff = CW'(1);
		end else if (num_taps > CW'(cdf_pkg::MAX_TAPS)) begin
			n_eff = CW'(cdf_pkg::MAX_TAPS);
		end else begin
			n_eff = num_taps;
		end
		half  = n_eff >> 1;
		lag   = n_eff - CW'(1) - half;
		d_eff = (decim_rate == '0) ? CW'(1) : decim_rate;
	end

	// during a flush every owed position counts, otherwise the window must be filled
	assign lim     = pe_q ? isamp_q : (isamp_q + IW'(lag));
	assign emit_ok = (nres_q != NW'(cdf_pkg::RESULT_CAP)) && (lim < IW'(count_q));

	// sample index must lie within this pulse and still be held in the circular line
	assign cnt_s  = $signed(SW'(count_q));
	assign in_win = !s_q[SW-1] && (s_q < cnt_s)
		&& ((s_q + SW'(cdf_pkg::MAX_TAPS)) >= cnt_s);

	assign item_pop = (state_q == ST_IDLE) && item_valid;
	assign dly_we   = item_pop && item.is_sample && (count_q != cdf_pkg::COUNT_LIMIT);
	assign coef_we  = item_pop && !item.is_sample;

	assign res_push          = (state_q == ST_PUSH) && !res_full;
	assign res.out_i         = r_i_q;
	assign res.out_q         = r_q_q;
	assign res.out_position  = pos_q;
	assign res.last_of_pulse = r_last_q;
	assign res.clipped       = r_clip_q;

	assign rs_re = rnd_sat(acc_re_q);
	assign rs_im = rnd_sat(acc_im_q);

	always_ff @(posedge clk) begin
		if (dly_we) begin
			dly_mem[count_q[AW-1:0]] <= {item.sample_i, item.sample_q};
		end
		if (coef_we) begin
			coef_mem[item.tap_index] <= item.tap_value;
		end
		dly_rd_s1  <= dly_mem[s_q[AW-1:0]];
		coef_rd_s1 <= coef_mem[i_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			win_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= (state_q == ST_MAC);
			win_s1 <= (state_q == ST_MAC) && in_win;
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (win_s1) begin
			prod_re_s2 <= coef_rd_s1 * $signed(dly_rd_s1[2*SB-1:SB]);
			prod_im_s2 <= coef_rd_s1 * $signed(dly_rd_s1[SB-1:0]);
		end else begin
			prod_re_s2 <= '0;
			prod_im_s2 <= '0;
		end
		if (state_q == ST_CHECK) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (act_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(prod_re_s2);
			acc_im_q <= acc_im_q + ACC_W'(prod_im_s2);
		end
		if (state_q == ST_RND) begin
			r_i_q    <= rs_re[SB-1:0];
			r_q_q    <= rs_im[SB-1:0];
			r_clip_q <= rs_re[SB] || rs_im[SB];
			r_last_q <= pe_q && ((nres_q == NW'(cdf_pkg::RESULT_CAP - 1))
				|| ((isamp_q + IW'(d_eff)) >= IW'(count_q)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			pe_q    <= 1'b0;
			nres_q  <= '0;
			isamp_q <= '0;
			s_q     <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_pop && item.is_sample) begin
						if (dly_we) begin
							count_q <= count_q + PSW'(1);
						end
						pe_q    <= item.pulse_end;
						nres_q  <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					isamp_q <= IW'(pos_q) * IW'(d_eff);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (emit_ok) begin
						s_q     <= $signed({1'b0, isamp_q}) - $signed(SW'(half));
						i_q     <= '0;
						state_q <= ST_MAC;
					end else begin
						if (pe_q) begin
							count_q <= '0;
							pos_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MAC: begin
					i_q <= i_q + AW'(1);
					s_q <= s_q + SW'(1);
					if (CW'(i_q) == (n_eff - CW'(1))) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!act_s1 && !act_s2) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!res_full) begin
						pos_q   <= pos_q + PSW'(1);
						nres_q  <= nres_q + NW'(1);
						isamp_q <= isamp_q + IW'(d_eff);
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (CW'(i_q) < n_eff))
		else $error("tap index past the taps in use");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !emit_ok && pe_q) |=> (count_q == '0 && pos_q == '0))
		else $error("pulse counters not cleared after flush");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |-> (!act_s1 && !act_s2 && !win_s1))
		else $error("rounding before the products are summed");

endmodule

/* src/complex_decimating_fir_unit.sv */
// Complex decimating FIR: I/Q samples arrive grouped into pulses, each pulse is
// filtered with num_taps real Q1.16 taps as though padded with zeros on both
// sides, and one result is produced for every decim_rate-th sample, centred on
// it, rounded and saturated to 16 bits with a clipped flag. Taps are loaded by
// pushing tap-write transactions (req_type low); they are undefined until
// written. A sample with pulse_end flushes up to 33 remaining results of the pulse
// (the last one carries last_of_pulse) and restarts the delay line. Registers:
// num_taps at address 0, decim_rate at address 4. Each result that a sample
// releases is computed on the single complex multiply-accumulate, which works
// one tap per cycle from the coefficient and delay-line memories; the engine
// takes no new transaction until every result of the current sample is queued.
module complex_decimating_fir_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [cdf_pkg::ADDR_W-1:0]              paddr,
	input  logic [cdf_pkg::DATA_W-1:0]              pwdata,
	output logic [cdf_pkg::DATA_W-1:0]              prdata,
	output logic                                    pready,
	input  logic                                    push,
	output logic                                    full,
	input  logic                                    req_type,
	input  logic [cdf_pkg::TAP_AW-1:0]              tap_index,
	input  logic signed [cdf_pkg::TAP_BITS-1:0]     tap_value,
	input  logic signed [cdf_pkg::SAMPLE_BITS-1:0]  sample_i,
	input  logic signed [cdf_pkg::SAMPLE_BITS-1:0]  sample_q,
	input  logic                                    pulse_end,
	output logic                                    empty,
	input  logic                                    pop,
	output logic signed [cdf_pkg::SAMPLE_BITS-1:0]  out_i,
	output logic signed [cdf_pkg::SAMPLE_BITS-1:0]  out_q,
	output logic [cdf_pkg::POS_W-1:0]               out_position,
	output logic                                    last_of_pulse,
	output logic                                    clipped
);

	logic [cdf_pkg::CFG_W-1:0] num_taps_q;
	logic [cdf_pkg::CFG_W-1:0] decim_rate_q;
	logic                      cfg_wr;
	logic                      item_valid;
	cdf_pkg::item_t            item;
	logic                      item_pop;
	logic                      res_full;
	logic                      res_push;
	cdf_pkg::result_t          res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// word address selects the register, byte offset bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q   <= cdf_pkg::NUM_TAPS_RST;
			decim_rate_q <= cdf_pkg::DECIM_RATE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				cdf_pkg::REG_NUM_TAPS:   num_taps_q   <= pwdata[cdf_pkg::CFG_W-1:0];
				cdf_pkg::REG_DECIM_RATE: decim_rate_q <= pwdata[cdf_pkg::CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cdf_pkg::REG_NUM_TAPS:   prdata = cdf_pkg::DATA_W'(num_taps_q);
			cdf_pkg::REG_DECIM_RATE: prdata = cdf_pkg::DATA_W'(decim_rate_q);
			default:                 prdata = '0;
		endcase
	end

	cdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.tap_index  (tap_index),
		.tap_value  (tap_value),
		.sample_i   (sample_i),
		.sample_q   (sample_q),
		.pulse_end  (pulse_end),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	cdf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_taps   (num_taps_q),
		.decim_rate (decim_rate_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	cdf_res_q u_res_q (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_push      (res_push),
		.res           (res),
		.res_full      (res_full),
		.empty         (empty),
		.pop           (pop),
		.out_i         (out_i),
		.out_q         (out_q),
		.out_position  (out_position),
		.last_of_pulse (last_of_pulse),
		.clipped       (clipped)
	);

endmodule

/* dv/tb_complex_decimating_fir_unit.sv */
`timescale 1ns / 1ps

module tb_complex_decimating_fir_unit;
	import cdf_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int SETTLE       = 300;
	localparam int TAP_FULL     = 131072;
	localparam int TAP_MAG_LOW  = 4096;
	localparam int TAP_MAG_MID  = 16384;
	localparam int PHASE_ITEMS  = 6;

	localparam logic signed [TAP_BITS-1:0]    TAP_MAX    = 18'sh1FFFF;
	localparam logic signed [TAP_BITS-1:0]    TAP_MIN    = 18'sh20000;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [ADDR_W-1:0]             paddr     = '0;
	logic [DATA_W-1:0]             pwdata    = '0;
	logic [DATA_W-1:0]             prdata;
	logic                          pready;
	logic                          push      = 1'b0;
	logic                          full;
	logic                          req_type  = REQ_TAP;
	logic [TAP_AW-1:0]             tap_index = '0;
	logic signed [TAP_BITS-1:0]    tap_value = '0;
	logic signed [SAMPLE_BITS-1:0] sample_i  = '0;
	logic signed [SAMPLE_BITS-1:0] sample_q  = '0;
	logic                          pulse_end = 1'b0;
	logic                          empty;
	logic                          pop       = 1'b0;
	logic signed [SAMPLE_BITS-1:0] out_i;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic [POS_W-1:0]              out_position;
	logic                          last_of_pulse;
	logic                          clipped;

	complex_decimating_fir_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.tap_index     (tap_index),
		.tap_value     (tap_value),
		.sample_i      (sample_i),
		.sample_q      (sample_q),
		.pulse_end     (pulse_end),
		.empty         (empty),
		.pop           (pop),
		.out_i         (out_i),
		.out_q         (out_q),
		.out_position  (out_position),
		.last_of_pulse (last_of_pulse),
		.clipped       (clipped)
	);

	always #HALF_PERIOD clk = ~clk;

	// filter state as the block should hold it
	logic [CFG_W-1:0]           cfg_taps;
	logic [CFG_W-1:0]           cfg_decim;
	int                         line_i [MAX_TAPS];
	int                         line_q [MAX_TAPS];
	logic signed [TAP_BITS-1:0] tap_coef [MAX_TAPS];
	int                         pulse_count;
	int                         out_index;

	item_t   fir_requests [$];
	item_t   cur_item;
	result_t outputs_due [$];
	logic    holding = 1'b0;
	int      send_idle = 0;
	int      recv_idle = 0;
	int      errors = 0;
	int      cycles = 0;

	task automatic report_mismatch(string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic logic [SAMPLE_BITS:0] round_clip(longint acc);
		longint r;
		r = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
		if (r > longint'(SAMPLE_MAX))
			return {1'b1, SAMPLE_MAX};
		if (r < longint'(SAMPLE_MIN))
			return {1'b1, SAMPLE_MIN};
		return {1'b0, r[SAMPLE_BITS-1:0]};
	endfunction

	function automatic result_t convolve_at(int isamp, int n, int h, int k);
		longint              acc_i;
		longint              acc_q;
		int                  j;
		int                  t;
		logic [SAMPLE_BITS:0] ri;
		logic [SAMPLE_BITS:0] rq;
		result_t             r;
		acc_i = 0;
		acc_q = 0;
		for (t = 0; t < n; t++) begin
			// samples older than the delay line or not yet received count as zero
			j = k - isamp + h - t;
			if (j >= 0 && j < MAX_TAPS) begin
				acc_i += longint'(tap_coef[t]) * line_i[j];
				acc_q += longint'(tap_coef[t]) * line_q[j];
			end
		end
		ri = round_clip(acc_i);
		rq = round_clip(acc_q);
		r.out_i         = ri[SAMPLE_BITS-1:0];
		r.out_q         = rq[SAMPLE_BITS-1:0];
		r.out_position  = POS_W'(out_index);
		r.last_of_pulse = 1'b0;
		r.clipped       = ri[SAMPLE_BITS] | rq[SAMPLE_BITS];
		return r;
	endfunction

	function automatic void filter_step(item_t it);
		int      n;
		int      h;
		int      lag;
		int      d;
		int      k;
		int      isamp;
		int      nres;
		int      s;
		result_t r;
		if (it.is_sample == REQ_TAP) begin
			tap_coef[it.tap_index] = it.tap_value;
			return;
		end
		n = int'(cfg_taps);
		if (n < 1)
			n = 1;
		if (n > MAX_TAPS)
			n = MAX_TAPS;
		h   = n / 2;
		lag = n - 1 - h;
		d   = (cfg_decim == '0) ? 1 : int'(cfg_decim);
		// an over-long pulse stops taking samples but still flushes
		if (pulse_count < int'(COUNT_LIMIT)) begin
			for (s = MAX_TAPS - 1; s > 0; s--) begin
				line_i[s] = line_i[s-1];
				line_q[s] = line_q[s-1];
			end
			line_i[0] = it.sample_i;
			line_q[0] = it.sample_q;
			pulse_count++;
		end
		k     = pulse_count - 1;
		nres  = 0;
		isamp = out_index * d;
		while (nres < RESULT_CAP &&
				(isamp + lag <= k || (it.pulse_end && isamp < pulse_count))) begin
			outputs_due.push_back(convolve_at(isamp, n, h, k));
			nres++;
			out_index++;
			isamp = out_index * d;
		end
		if (it.pulse_end) begin
			if (nres > 0) begin
				r = outputs_due.pop_back();
				r.last_of_pulse = 1'b1;
				outputs_due.push_back(r);
			end
			line_i      = '{default: 0};
			line_q      = '{default: 0};
			pulse_count = 0;
			out_index   = 0;
		end
	endfunction

	// driver: holds each item until the block takes it
	always @(posedge clk) begin
		if (!arst_n) begin
			holding = 1'b0;
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				filter_step(cur_item);
				holding = 1'b0;
			end
			if (!holding && fir_requests.size() != 0 && $urandom_range(99) >= send_idle) begin
				cur_item = fir_requests.pop_front();
				holding  = 1'b1;
				req_type  <= cur_item.is_sample;
				tap_index <= cur_item.tap_index;
				tap_value <= cur_item.tap_value;
				sample_i  <= cur_item.sample_i;
				sample_q  <= cur_item.sample_q;
				pulse_end <= cur_item.pulse_end;
			end
			push <= holding;
		end
	end

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
			logic [POS_W-1:0] pos);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h at position %0d",
				name, got, want, pos));
	endtask

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (outputs_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result at position %0d", out_position));
				end else begin
					want = outputs_due.pop_front();
					check_field("out_i", out_i, want.out_i, want.out_position);
					check_field("out_q", out_q, want.out_q, want.out_position);
					check_field("out_position", out_position, want.out_position,
						want.out_position);
					check_field("last_of_pulse", last_of_pulse, want.last_of_pulse,
						want.out_position);
					check_field("clipped", clipped, want.clipped, want.out_position);
				end
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_complex_decimating_fir_unit NOT OK");
			$finish;
		end
	end

	task automatic apb_access(input logic [ADDR_W-1:0] addr, input logic wr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic cfg_reg(logic reg_sel, logic [CFG_W-1:0] value);
		logic [DATA_W-1:0] rd;
		apb_access(ADDR_W'(4 * int'(reg_sel)), 1'b1, DATA_W'(value), rd);
		apb_access(ADDR_W'(4 * int'(reg_sel)), 1'b0, '0, rd);
		if (rd !== DATA_W'(value))
			report_mismatch($sformatf("register %0d reads %0h after writing %0h",
				reg_sel, rd, value));
		if (reg_sel == REG_NUM_TAPS)
			cfg_taps = value;
		else
			cfg_decim = value;
	endtask

	// wait until every transaction has gone through and the engine has settled
	task automatic wait_idle();
		while (fir_requests.size() != 0 || holding || outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_filter(logic [CFG_W-1:0] taps, logic [CFG_W-1:0] decim);
		wait_idle();
		cfg_reg(REG_NUM_TAPS, taps);
		cfg_reg(REG_DECIM_RATE, decim);
	endtask

	function automatic logic signed [TAP_BITS-1:0] rand_tap(int mag);
		int v;
		v = int'($urandom_range(2 * mag - 1)) - mag;
		return TAP_BITS'(v);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// unused fields carry junk so the block is seen to ignore them
	function automatic item_t tap_item(logic [TAP_AW-1:0] idx,
			logic signed [TAP_BITS-1:0] val, logic pend);
		item_t it;
		it.is_sample = REQ_TAP;
		it.tap_index = idx;
		it.tap_value = val;
		it.sample_i  = SAMPLE_BITS'($urandom);
		it.sample_q  = SAMPLE_BITS'($urandom);
		it.pulse_end = pend;
		return it;
	endfunction

	function automatic item_t sample_item(logic signed [SAMPLE_BITS-1:0] si,
			logic signed [SAMPLE_BITS-1:0] sq, logic pend);
		item_t it;
		it.is_sample = REQ_SAMPLE;
		it.tap_index = TAP_AW'($urandom);
		it.tap_value = TAP_BITS'($urandom);
		it.sample_i  = si;
		it.sample_q  = sq;
		it.pulse_end = pend;
		return it;
	endfunction

	task automatic load_taps(int mag);
		for (int t = 0; t < MAX_TAPS; t++)
			fir_requests.push_back(tap_item(TAP_AW'(t), rand_tap(mag), 1'($urandom)));
	endtask

	// a pulse of random samples with the odd tap rewrite mixed in
	task automatic queue_pulse(int len, bit closed, int mag);
		for (int s = 0; s < len; s++) begin
			if ($urandom_range(19) == 0)
				fir_requests.push_back(tap_item(TAP_AW'($urandom),
					($urandom_range(3) == 0) ? rand_tap(TAP_FULL) : rand_tap(mag),
					1'($urandom)));
			fir_requests.push_back(sample_item(rand_sample(), rand_sample(),
				closed && s == len - 1));
		end
	endtask

	task automatic run_random(logic [CFG_W-1:0] taps, logic [CFG_W-1:0] decim, int mag);
		int queued;
		int len;
		set_filter(taps, decim);
		queued = 0;
		while (queued < PHASE_ITEMS) begin
			case ($urandom_range(19))
				0: len = $urandom_range(41, 120);
				1, 2, 3, 4, 5: len = $urandom_range(13, 40);
				default: len = $urandom_range(1, 12);
			endcase
			// the last pulse may stay open across the next register change
			queue_pulse(len, (queued + len < PHASE_ITEMS) || $urandom_range(1), mag);
			queued += len;
		end
	endtask

	initial begin
		cfg_taps    = NUM_TAPS_RST;
		cfg_decim   = DECIM_RATE_RST;
		line_i      = '{default: 0};
		line_q      = '{default: 0};
		pulse_count = 0;
		out_index   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		send_idle = 8;
		recv_idle = 46;
		set_filter(NUM_TAPS_RST, DECIM_RATE_RST);
		load_taps(TAP_MAG_LOW);

		// tap extremes; the centre taps are large so that both rails clip
		fir_requests.push_back(tap_item('0, TAP_MAX, 1'b0));
		fir_requests.push_back(tap_item('1, TAP_MIN, 1'b1));
		fir_requests.push_back(tap_item(TAP_AW'(8), TAP_MIN, 1'b0));
		fir_requests.push_back(tap_item(TAP_AW'(9), TAP_MAX, 1'b1));
		fir_requests.push_back(sample_item(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
		fir_requests.push_back(sample_item(SAMPLE_MIN, SAMPLE_MAX, 1'b0));
		fir_requests.push_back(sample_item(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
		fir_requests.push_back(sample_item(SAMPLE_MIN, SAMPLE_MAX, 1'b0));
		fir_requests.push_back(sample_item('0, '0, 1'b0));
		fir_requests.push_back(sample_item(SAMPLE_MAX, SAMPLE_MAX, 1'b1));
		// one-sample pulse
		fir_requests.push_back(sample_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1));

		// short pulses at decimation four: one flush owes nothing, one owes a result
		set_filter(7'd4, 7'd4);
		queue_pulse(3, 1'b1, TAP_MAG_LOW);
		queue_pulse(5, 1'b1, TAP_MAG_LOW);

		// backlog with samples beyond the delay line, cut short by the flush
		set_filter(7'd4, 7'd64);
		queue_pulse(70, 1'b0, TAP_MAG_LOW);
		set_filter(7'd4, 7'd1);
		queue_pulse(1, 1'b1, TAP_MAG_LOW);

		// backlog spread over several transactions
		set_filter(7'd64, 7'd2);
		queue_pulse(44, 1'b0, TAP_MAG_LOW);
		set_filter(7'd4, 7'd1);
		queue_pulse(3, 1'b1, TAP_MAG_LOW);

		run_random(7'd16, 7'd1, TAP_MAG_LOW);
		run_random(7'd64, 7'd64, TAP_MAG_LOW);
		run_random(7'd5, 7'd3, TAP_MAG_LOW);

		wait_idle();
		send_idle = 46;
		recv_idle = 8;
		load_taps(TAP_FULL);
		run_random(7'd64, 7'd1, TAP_FULL);
		run_random(7'd4, 7'd1, TAP_FULL);
		run_random(7'd33, 7'd7, TAP_FULL);

		wait_idle();
		send_idle = 0;
		recv_idle = 0;
		load_taps(TAP_MAG_MID);
		run_random(7'd4, 7'd64, TAP_MAG_MID);
		run_random(7'd7, 7'd2, TAP_MAG_MID);
		run_random(7'd64, 7'd5, TAP_MAG_MID);

		wait_idle();
		if (outputs_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", outputs_due.size()));
		if (errors == 0)
			$display("tb_complex_decimating_fir_unit OK");
		else
			$display("tb_complex_decimating_fir_unit NOT OK");
		$finish;
	end

endmodule
